FILE: hw/rtl/binary_to_roman_numeral_assert.svh
// Assertion macros for the binary to Roman numeral converter.
`ifndef BINARY_TO_ROMAN_NUMERAL_ASSERT_SVH
`define BINARY_TO_ROMAN_NUMERAL_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define B2R_ASSERT_NOW(label_n, cond_a, cond_c, msg) \
  label_n: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond_a) |-> (cond_c)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define B2R_ASSERT_NEXT(label_n, cond_a, cond_c, msg) \
  label_n: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond_a) |=> (cond_c)) else $error(msg);

`endif

FILE: hw/rtl/b2r_pkg.sv
// Shared types and constants of the binary to Roman numeral converter.
package b2r_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned SymW   = 7;

  localparam logic [SymW-1:0] SYM_C = 7'h43;
  localparam logic [SymW-1:0] SYM_D = 7'h44;
  localparam logic [SymW-1:0] SYM_I = 7'h49;
  localparam logic [SymW-1:0] SYM_L = 7'h4C;
  localparam logic [SymW-1:0] SYM_M = 7'h4D;
  localparam logic [SymW-1:0] SYM_V = 7'h56;
  localparam logic [SymW-1:0] SYM_X = 7'h58;

  typedef struct packed {
    logic [ValueW-1:0] weight;
    logic [SymW-1:0]   first;
    logic [SymW-1:0]   second;
    logic              pair;
  } b2r_token_t;

  localparam int unsigned TokenNum = 13;
  localparam int unsigned TokIdxW  = $clog2(TokenNum);

  // Greedy token table, largest weight first.
  localparam b2r_token_t TOKENS [TokenNum] = '{
    '{12'd1000, SYM_M, SYM_M, 1'b0},
    '{12'd900,  SYM_C, SYM_M, 1'b1},
    '{12'd500,  SYM_D, SYM_D, 1'b0},
    '{12'd400,  SYM_C, SYM_D, 1'b1},
    '{12'd100,  SYM_C, SYM_C, 1'b0},
    '{12'd90,   SYM_X, SYM_C, 1'b1},
    '{12'd50,   SYM_L, SYM_L, 1'b0},
    '{12'd40,   SYM_X, SYM_L, 1'b1},
    '{12'd10,   SYM_X, SYM_X, 1'b0},
    '{12'd9,    SYM_I, SYM_X, 1'b1},
    '{12'd5,    SYM_V, SYM_V, 1'b0},
    '{12'd4,    SYM_I, SYM_V, 1'b1},
    '{12'd1,    SYM_I, SYM_I, 1'b0}
  };

  typedef enum logic {
    B2R_IDLE,
    B2R_RUN
  } b2r_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } b2r_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic step_last;
  } b2r_stat_t;

endpackage

FILE: hw/rtl/binary_to_roman_numeral.sv
// Top level of the binary to Roman numeral converter.
//
// Input channel: in_valid_i / in_ready_o carry one 12-bit unsigned value_i per beat.
// Output channel: out_valid_o / out_ready_i carry one ASCII letter per beat on
// symbol_o, most significant first, with last_o high on the final letter.
// A value of 0 is taken and gives no output beats; 4000 and above lead with MMMM.
// The input value is registered as the remainder; the first letter is then picked
// from it and registered on symbol_o. Letters follow at one letter per cycle
// while the receiver is ready; a nonzero value has 1 to 15 letters.
// The rate is set by the single greedy token picker, which yields one letter
// per step from a registered remainder.
// The next value is taken as soon as the last letter sits in the output
// register, even while that beat still waits to be taken.
// When the receiver stalls, the output beat holds and no further letter is
// produced. Reset clears the controller to idle with no output beat pending.
module binary_to_roman_numeral (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [b2r_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [b2r_pkg::SymW-1:0]    symbol_o,
  output logic                        last_o
);
  import b2r_pkg::*;

  b2r_cmd_t  cmd;
  b2r_stat_t stat;

  b2r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  b2r_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .symbol_o(symbol_o),
    .last_o  (last_o)
  );

endmodule

FILE: hw/rtl/b2r_ctrl.sv
// Controller state machine of the binary to Roman numeral converter.
module b2r_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  b2r_pkg::b2r_stat_t stat_i,
  output b2r_pkg::b2r_cmd_t  cmd_o
);
  import b2r_pkg::*;

  b2r_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B2R_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      B2R_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!stat_i.in_zero) begin
            state_d = B2R_RUN;
          end
        end
      end
      B2R_RUN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.step  = 1'b1;
          out_valid_d = 1'b1;
          if (stat_i.step_last) begin
            state_d = B2R_IDLE;
          end
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/b2r_dp.sv
// Datapath of the binary to Roman numeral converter: remainder, token pick, output beat.
module b2r_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [b2r_pkg::ValueW-1:0]  value_i,
  input  b2r_pkg::b2r_cmd_t           cmd_i,
  output b2r_pkg::b2r_stat_t          stat_o,
  output logic [b2r_pkg::SymW-1:0]    symbol_o,
  output logic                        last_o
);
  import b2r_pkg::*;

  logic [ValueW-1:0] rem_q, rem_d;
  logic              pend_q, pend_d;
  logic [SymW-1:0]   pend_sym_q, pend_sym_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic              last_q, last_d;
  logic [TokIdxW-1:0] tok_idx;
  b2r_token_t        tok;

  // Largest token weight not above the remainder.
  always_comb begin
    tok_idx = TokIdxW'(TokenNum - 1);
    for (int i = TokenNum - 1; i >= 0; i--) begin
      if (rem_q >= TOKENS[i].weight) begin
        tok_idx = TokIdxW'(i);
      end
    end
  end

  assign tok = TOKENS[tok_idx];

  always_comb begin
    if (pend_q) begin
      sym_d      = pend_sym_q;
      rem_d      = rem_q;
      pend_d     = 1'b0;
      pend_sym_d = pend_sym_q;
      last_d     = (rem_q == '0);
    end else begin
      sym_d      = tok.first;
      rem_d      = rem_q - tok.weight;
      pend_d     = tok.pair;
      pend_sym_d = tok.second;
      last_d     = !tok.pair && (rem_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (cmd_i.load) begin
      pend_q <= 1'b0;
    end else if (cmd_i.step) begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= value_i;
    end else if (cmd_i.step) begin
      rem_q      <= rem_d;
      pend_sym_q <= pend_sym_d;
      sym_q      <= sym_d;
      last_q     <= last_d;
    end
  end

  assign stat_o.in_zero   = (value_i == '0);
  assign stat_o.step_last = last_d;
  assign symbol_o         = sym_q;
  assign last_o           = last_q;

endmodule

FILE: hw/rtl/b2r_chk.sv
// Port-level checker of the binary to Roman numeral converter, bound to the top level.
`include "binary_to_roman_numeral_assert.svh"

module b2r_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [b2r_pkg::ValueW-1:0]  value_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [b2r_pkg::SymW-1:0]    symbol_o,
  input logic                        last_o
);
  import b2r_pkg::*;

  `B2R_ASSERT_NOW(a_sym_legal, out_valid_o, (symbol_o == SYM_C || symbol_o == SYM_D || symbol_o == SYM_I || symbol_o == SYM_L || symbol_o == SYM_M || symbol_o == SYM_V || symbol_o == SYM_X), "symbol is not a Roman letter")
  `B2R_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(symbol_o) && $stable(last_o), "stalled output beat changed")
  `B2R_ASSERT_NEXT(a_busy_after_load, in_valid_i && in_ready_o && value_i != '0, !in_ready_o, "input taken while converting")
  `B2R_ASSERT_NEXT(a_run_continues, out_valid_o && out_ready_i && !last_o, out_valid_o, "gap inside a numeral")
  `B2R_ASSERT_NOW(a_no_take_midword, out_valid_o && !last_o, !in_ready_o, "ready before numeral end")

endmodule

bind binary_to_roman_numeral b2r_chk u_chk (.*);
